// File: rtl/core/ipt_pkg.sv
// Shared types and constants for the inverted page table.
// No dependencies; imported by every module of the block.
package ipt_pkg;

  localparam int unsigned PID_W    = 8;
  localparam int unsigned VPN_W    = 8;
  localparam int unsigned FRAME_W  = 7;
  localparam int unsigned VA_W     = 32;
  localparam int unsigned PA_W     = 18;
  localparam int unsigned HF_W     = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CMD_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_INVALIDATE = 2'd1,
    CMD_TRANSLATE  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_MISS        = 2'd1,
    ST_ADDR_RANGE  = 2'd2,
    ST_FRAME_RANGE = 2'd3
  } status_e;

  // Search key broadcast to every cell.
  typedef struct packed {
    logic             ok;
    logic [PID_W-1:0] pid;
    logic [VPN_W-1:0] page;
  } key_t;

  // Table update broadcast to every cell.
  typedef struct packed {
    logic               insert;
    logic               inval;
    logic [FRAME_W-1:0] frame;
  } upd_t;

endpackage

// File: rtl/core/ipt_cell.sv
// One slot of the inverted page table: pid, page and valid mark of one frame.
// Depends on ipt_pkg.
module ipt_cell import ipt_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  key_t key_i,
  input  logic search_i,
  input  upd_t upd_i,
  output logic match_o
);

  logic             valid_q, valid_d;
  logic             match_q;
  logic [PID_W-1:0] pid_q;
  logic [VPN_W-1:0] page_q;
  logic             tgt;

  assign tgt = (32'(upd_i.frame) == 32'(CELL_IDX));

  always_comb begin
    valid_d = valid_q;
    if (upd_i.insert && tgt) begin
      valid_d = 1'b1;
    end else if ((upd_i.insert || upd_i.inval) && match_q) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (search_i) begin
        match_q <= valid_q && key_i.ok && (pid_q == key_i.pid) && (page_q == key_i.page);
      end
    end
  end

  // Slot contents only matter while valid.
  always_ff @(posedge clk_i) begin
    if (upd_i.insert && tgt) begin
      pid_q  <= key_i.pid;
      page_q <= key_i.page;
    end
  end

  assign match_o = match_q;

endmodule

// File: rtl/core/ipt_encode.sv
// Turns the row of cell match bits into the matching frame index.
// Depends on ipt_pkg; at most one cell matches at a time.
module ipt_encode import ipt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 64,
  localparam int unsigned IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic [SLOT_COUNT-1:0] match_i,
  output logic [IDX_W-1:0]      idx_o,
  output logic                  any_o
);

  always_comb begin
    idx_o = '0;
    for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
      if (match_i[i]) begin
        idx_o = idx_o | IDX_W'(i);
      end
    end
  end

  assign any_o = |match_i;

endmodule

// File: rtl/core/inverted_page_table.sv
// Top level of the inverted page table: command intake, control sequence,
// row of slot cells and the result register. Depends on ipt_pkg, ipt_cell, ipt_encode.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | sink      | in_valid_i / in_ready_o   | command, pid, vpn, frame, vaddr
//  out     | source    | out_valid_o / out_ready_i | status, physical_address, hit_frame
//
// Sequence: one item at a time, in the steps intake, search, update and result;
// the cell row is compared once per item.
// Reset: all slot valid marks clear at once; the block takes a beat in the first
// cycle after reset.
// Stalls: the result step holds while an earlier result beat waits in the output
// register; the next beat is taken in the cycle after the result loads, so a
// stalled receiver adds its wait to the time for each item.
module inverted_page_table import ipt_pkg::*; #(
  parameter int unsigned       SLOT_COUNT          = 64,
  parameter int unsigned       PAGE_BYTES          = 4096,
  parameter longint unsigned   VIRTUAL_SPACE_BYTES = 1048576
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [PID_W-1:0]    pid_i,
  input  logic [VPN_W-1:0]    vpn_i,
  input  logic [FRAME_W-1:0]  frame_i,
  input  logic [VA_W-1:0]     vaddr_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [PA_W-1:0]     physical_address_o,
  output logic [HF_W-1:0]     hit_frame_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned OFF_W = $clog2(PAGE_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_APPLY,
    S_RESULT
  } state_e;

  state_e state_q;

  // Captured beat, decoded at intake.
  cmd_e               cmd_q;
  logic [FRAME_W-1:0] frame_q;
  logic [OFF_W-1:0]   off_q;
  logic               addr_bad_q;
  logic               frame_bad_q;
  key_t               key_q, key_d;

  logic                  in_fire;
  logic [VA_W-1:0]       page_full;
  logic                  addr_bad_d;
  cmd_e                  cmd_in;

  logic [SLOT_COUNT-1:0] match;
  logic [IDX_W-1:0]      enc_idx;
  logic                  enc_any;
  logic [IDX_W-1:0]      idx_q;
  logic                  any_q;

  upd_t                  upd;
  logic                  search;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [PA_W-1:0]       phys_q;
  logic [HF_W-1:0]       hit_q;

  status_e               res_status;
  logic [PA_W-1:0]       res_phys;
  logic [HF_W-1:0]       res_hit;
  logic [31:0]           phys_full;
  logic [31:0]           idx_ext;
  logic                  out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign cmd_in     = cmd_e'(command_i);

  // Split the address into page and offset; a page beyond the 8-bit field never matches.
  assign page_full  = vaddr_i / PAGE_BYTES;
  assign addr_bad_d = (64'(vaddr_i) >= VIRTUAL_SPACE_BYTES);

  always_comb begin
    key_d.pid = pid_i;
    if (cmd_in == CMD_TRANSLATE) begin
      key_d.page = page_full[VPN_W-1:0];
      key_d.ok   = !addr_bad_d && (page_full < (VA_W'(1) << VPN_W));
    end else begin
      key_d.page = vpn_i;
      key_d.ok   = 1'b1;
    end
  end

  // Capture the beat; contents are only used while the sequence runs.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q       <= cmd_in;
      frame_q     <= frame_i;
      off_q       <= OFF_W'(vaddr_i % PAGE_BYTES);
      addr_bad_q  <= addr_bad_d;
      frame_bad_q <= (32'(frame_i) >= 32'(SLOT_COUNT));
      key_q       <= key_d;
    end
  end

  // Compare all cells in the search step, apply the table update in the next.
  assign search      = (state_q == S_SEARCH);
  assign upd.insert  = (state_q == S_APPLY) && (cmd_q == CMD_INSERT) && !frame_bad_q;
  assign upd.inval   = (state_q == S_APPLY) && (cmd_q == CMD_INVALIDATE);
  assign upd.frame   = frame_q;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    ipt_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key_q),
      .search_i(search),
      .upd_i   (upd),
      .match_o (match[g])
    );
  end

  ipt_encode #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_encode (
    .match_i(match),
    .idx_o  (enc_idx),
    .any_o  (enc_any)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_APPLY) begin
      idx_q <= enc_idx;
      any_q <= enc_any;
    end
  end

  // Result formatting from the registered hit.
  assign idx_ext   = 32'(idx_q);
  assign phys_full = idx_ext * PAGE_BYTES + 32'(off_q);

  always_comb begin
    res_status = ST_OK;
    res_phys   = '0;
    res_hit    = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (frame_bad_q) res_status = ST_FRAME_RANGE;
      end
      CMD_INVALIDATE: begin
        if (any_q) res_hit = idx_ext[HF_W-1:0];
      end
      CMD_TRANSLATE: begin
        if (addr_bad_q) begin
          res_status = ST_ADDR_RANGE;
        end else if (!any_q) begin
          res_status = ST_MISS;
        end else begin
          res_hit  = idx_ext[HF_W-1:0];
          res_phys = phys_full[PA_W-1:0];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Sequence control and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      phys_q      <= '0;
      hit_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) state_q <= S_SEARCH;
        end
        S_SEARCH: begin
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          // Hold until the previous result beat has left.
          if (out_free) begin
            status_q    <= res_status;
            phys_q      <= res_phys;
            hit_q       <= res_hit;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      // Raise valid when a result loads, drop it once the beat is taken.
      if ((state_q == S_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign physical_address_o = phys_q;
  assign hit_frame_o        = hit_q;

  // A pair lives in at most one valid slot.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("more than one slot matched the search key");

  // A new result beat appears only from the result step.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESULT))
    else $error("result beat raised outside the result step");

  // Only one item is in flight.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while an item is in flight");

endmodule
